// ===== src/lmfb_pkg.sv =====
// Shared types and constants for the LIN master frame builder.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package lmfb_pkg;

  // Largest payload that one frame carries.
  localparam int MAX_PAYLOAD = 8;

  // Field widths of a frame request.
  localparam int ID_W   = 6;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int BYTE_W = 8;

  // Width of the remaining payload byte counter.
  localparam int REM_W = $clog2(MAX_PAYLOAD + 1);

  // Fixed line bytes.
  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0] BREAK_BYTE = 8'h00;
  localparam logic [ID_W-1:0]   ID_MASK    = 6'h3F;

  // One classified frame, as it waits between front and back.
  typedef struct packed {
    logic [BYTE_W-1:0] pid;
    logic              master;
    logic [REM_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } job_t;

endpackage

// ===== src/lmfb_if.sv =====
// Valid/ready channel interfaces for frame requests and transmit bytes.
// Depends on lmfb_pkg for the field widths.
`timescale 1ns / 1ps

interface lmfb_req_if;
  logic                          valid;
  logic                          ready;
  logic [lmfb_pkg::ID_W-1:0]     frame_id;
  logic                          master_frame;
  logic [lmfb_pkg::LEN_W-1:0]    payload_length;
  logic [lmfb_pkg::DATA_W-1:0]   payload_bytes;

  modport source (output valid, frame_id, master_frame, payload_length, payload_bytes,
                  input ready);
  modport sink (input valid, frame_id, master_frame, payload_length, payload_bytes,
                output ready);
endinterface

interface lmfb_byte_if;
  logic                          valid;
  logic                          ready;
  logic [lmfb_pkg::BYTE_W-1:0]   tx_byte;
  logic                          send_break;
  logic                          last_byte;

  modport source (output valid, tx_byte, send_break, last_byte, input ready);
  modport sink (input valid, tx_byte, send_break, last_byte, output ready);
endinterface

// ===== src/lmfb_front.sv =====
// Front end: accepts frame requests, adds the PID parity and clamps the length.
// Depends on lmfb_pkg and the request interface in lmfb_if.
`timescale 1ns / 1ps

module lmfb_front (
  lmfb_req_if.sink          req,
  input  logic              full,
  output logic              push,
  output lmfb_pkg::job_t    job
);

  logic [lmfb_pkg::ID_W-1:0] id;
  logic                      p0;
  logic                      p1;

  // Protected identifier: P0 even parity, P1 inverted parity.
  always_comb begin
    id = req.frame_id & lmfb_pkg::ID_MASK;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
  end

  // Build the queued job; the length saturates at the payload limit.
  always_comb begin
    job.pid    = {p1, p0, id};
    job.master = req.master_frame;
    if (req.payload_length > lmfb_pkg::LEN_W'(lmfb_pkg::MAX_PAYLOAD)) begin
      job.len = lmfb_pkg::REM_W'(lmfb_pkg::MAX_PAYLOAD);
    end else begin
      job.len = lmfb_pkg::REM_W'(req.payload_length);
    end
    job.data = req.payload_bytes;
  end

  assign req.ready = ~full;
  assign push      = req.valid & ~full;

endmodule

// ===== src/lmfb_queue.sv =====
// Two-entry job queue between the front end and the byte sequencer.
// Depends on lmfb_pkg for the job type.
`timescale 1ns / 1ps

module lmfb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lmfb_pkg::job_t    push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output lmfb_pkg::job_t    head
);

  lmfb_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop & not_empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");

  // The count never exceeds the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

  // A pop with a push keeps the count.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (push && do_pop) |=> $stable(count))
    else $error("queue count moved on simultaneous push and pop");

endmodule

// ===== src/lmfb_back.sv =====
// Back end: walks one job through break, sync, PID and, for master frames, payload and checksum bytes.
// Depends on lmfb_pkg and the byte interface in lmfb_if.
`timescale 1ns / 1ps

module lmfb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lmfb_pkg::job_t    q_head,
  output logic              pop,
  lmfb_byte_if.source       tx
);

  localparam logic [2:0] ST_BREAK = 3'd0;
  localparam logic [2:0] ST_SYNC  = 3'd1;
  localparam logic [2:0] ST_PID   = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic                           busy;
  logic                           master;
  logic [lmfb_pkg::BYTE_W-1:0]    pid;
  logic [lmfb_pkg::REM_W-1:0]     rem;
  logic [lmfb_pkg::DATA_W-1:0]    data;
  logic [lmfb_pkg::BYTE_W-1:0]    sum;
  logic [lmfb_pkg::BYTE_W:0]      sum_wide;
  logic [lmfb_pkg::BYTE_W-1:0]    sum_next;

  logic                           out_valid;
  logic [lmfb_pkg::BYTE_W-1:0]    out_byte;
  logic                           out_break;
  logic                           out_last;

  logic [lmfb_pkg::BYTE_W-1:0]    cur_byte;
  logic                           cur_break;
  logic                           cur_last;
  logic                           advance;

  // The output register frees whenever it is empty or being taken.
  assign advance = busy & (~out_valid | tx.ready);
  assign pop     = ~busy | (advance & cur_last);

  // End-around carry add of the current payload byte.
  always_comb begin
    sum_wide = {1'b0, sum} + {1'b0, data[lmfb_pkg::BYTE_W-1:0]};
    sum_next = sum_wide[lmfb_pkg::BYTE_W-1:0] + {{(lmfb_pkg::BYTE_W-1){1'b0}}, sum_wide[lmfb_pkg::BYTE_W]};
  end

  // Byte for the current step and the step after it.
  always_comb begin
    cur_byte   = lmfb_pkg::BREAK_BYTE;
    cur_break  = 1'b0;
    cur_last   = 1'b0;
    state_next = state;
    unique case (state)
      ST_BREAK: begin
        cur_byte   = lmfb_pkg::BREAK_BYTE;
        cur_break  = 1'b1;
        state_next = ST_SYNC;
      end
      ST_SYNC: begin
        cur_byte   = lmfb_pkg::SYNC_BYTE;
        state_next = ST_PID;
      end
      ST_PID: begin
        cur_byte = pid;
        cur_last = ~master;
        if (!master) begin
          state_next = ST_BREAK;
        end else if (rem == '0) begin
          state_next = ST_SUM;
        end else begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        cur_byte = data[lmfb_pkg::BYTE_W-1:0];
        if (rem == lmfb_pkg::REM_W'(1)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cur_byte   = ~sum;
        cur_last   = 1'b1;
        state_next = ST_BREAK;
      end
      default: begin
        state_next = ST_BREAK;
      end
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      state <= ST_BREAK;
    end else if (pop && q_valid) begin
      busy  <= 1'b1;
      state <= ST_BREAK;
    end else if (advance) begin
      state <= state_next;
      if (cur_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Job payload, remaining count and running checksum.
  always_ff @(posedge clk) begin
    if (pop && q_valid) begin
      master <= q_head.master;
      pid    <= q_head.pid;
      rem    <= q_head.len;
      data   <= q_head.data;
      sum    <= '0;
    end else if (advance && state == ST_DATA) begin
      rem  <= rem - lmfb_pkg::REM_W'(1);
      data <= data >> lmfb_pkg::BYTE_W;
      sum  <= sum_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= cur_byte;
      out_break <= cur_break;
      out_last  <= cur_last;
    end
  end

  assign tx.valid      = out_valid;
  assign tx.tx_byte    = out_byte;
  assign tx.send_break = out_break;
  assign tx.last_byte  = out_last;

  // A break marker always opens a frame and never closes it.
  a_break_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_break) |-> !out_last)
    else $error("break byte marked as last");

  // The payload counter stays within the payload limit while a job runs.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem <= lmfb_pkg::REM_W'(lmfb_pkg::MAX_PAYLOAD)))
    else $error("payload counter out of range");

  // Finishing a frame with nothing queued leaves the sequencer idle at break.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && cur_last && !q_valid) |=> (!busy && state == ST_BREAK))
    else $error("sequencer did not return to idle");

  // A payload step is only reached by a master frame.
  a_data_master: assert property (@(posedge clk) disable iff (rst)
    (busy && state == ST_DATA) |-> (master && rem != '0))
    else $error("payload step without payload");

endmodule

// ===== src/lin_master_frame_builder.sv =====
// LIN master frame builder: top level joining front end, job queue and sequencer.
// Depends on lmfb_pkg, lmfb_if, lmfb_front, lmfb_queue and lmfb_back.
//
// Usage:
//   req carries one frame request: frame_id, master_frame, payload_length and
//   payload_bytes (byte 0 in bits 7:0). A request is taken when req.valid and
//   req.ready are both high at a rising edge of clk.
//   tx carries the line bytes in order: a dummy 0x00 with send_break set, the
//   sync byte 0x55, the protected identifier, then for master frames the
//   payload bytes (length clamped to eight) and the classic checksum.
//   last_byte marks the final byte of each frame.
// Throughput: one byte per cycle on tx while tx.ready is high, set by the single
//   output byte register; a frame is 3 bytes (header only) or length + 4 bytes
//   (master frame), at most 12. Frames follow back to back when one is queued.
// A request taken while the queue and sequencer are empty is stored in the queue,
//   loaded into the sequencer job registers, then sent from the output register.
// A two-entry queue holds requests while earlier frames are sent, so req stays
//   ready until two requests wait. When tx stalls, the current byte holds and
//   the sequencer and queue stop with it.
// Reset (rst, synchronous, active high) empties the queue and the sequencer.
`timescale 1ns / 1ps

module lin_master_frame_builder (
  input  logic         clk,
  input  logic         rst,
  lmfb_req_if.sink     req,
  lmfb_byte_if.source  tx
);

  logic           full;
  logic           push;
  logic           pop;
  logic           q_valid;
  lmfb_pkg::job_t push_job;
  lmfb_pkg::job_t q_head;

  // Request intake and classification.
  lmfb_front u_front (
    .req  (req),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  // Decoupling queue.
  lmfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Byte sequencer and output register.
  lmfb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .tx      (tx)
  );

endmodule
